@@ sv/tgr_pkg.sv @@
// Package for the touch gesture recognizer: widths, codes, reset values.
// No dependencies.
package tgr_pkg;
   localparam int COORD_WIDTH_DEF    = 16;
   localparam int TIMER_WIDTH_DEF    = 16;
   localparam int DIST_FRAC_BITS_DEF = 4;
   localparam int PAN_THR_W  = 17;
   localparam int PINCH_THR_W = 21;
   localparam int DTAP_W     = 17;
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;
   localparam int EVENT_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PAN_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PINCH_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DTAP_DIST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DTAP_TICKS = 3'd4;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_TWO  = 2'd2;

   localparam logic [1:0] ST_PRESSED    = 2'd0;
   localparam logic [1:0] ST_STATIONARY = 2'd1;
   localparam logic [1:0] ST_MOVED      = 2'd2;
   localparam logic [1:0] ST_RELEASED   = 2'd3;

   localparam logic [EVENT_W-1:0] EV_TAP_START = 3'd0;
   localparam logic [EVENT_W-1:0] EV_TAP_END   = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_HOLD      = 3'd3;
   localparam logic [EVENT_W-1:0] EV_PAN_START = 3'd4;
   localparam logic [EVENT_W-1:0] EV_PAN       = 3'd5;
   localparam logic [EVENT_W-1:0] EV_PAN_END   = 3'd6;
   localparam logic [EVENT_W-1:0] EV_PINCH     = 3'd7;

   localparam logic [PAN_THR_W-1:0]   PAN_THR_RST   = 17'd20;
   localparam logic [PINCH_THR_W-1:0] PINCH_THR_RST = 21'd160;
   localparam logic [DTAP_W-1:0]      DTAP_DIST_RST = 17'd40;
   localparam logic [TICKS_W-1:0]     HOLD_RST      = 16'd1000;
   localparam logic [TICKS_W-1:0]     DTAP_TICKS_RST = 16'd750;
endpackage

@@ sv/touch_gesture_recognizer.sv @@
// Touch gesture recognizer top level: sequencer, gesture state, result slots.
// Ticks and one-point reports go from S_IDLE straight to S_OUT; two-point
// reports with both points down first pass S_SQRT, which waits on the
// bit-serial square root, and then S_PINCH.
// One item at a time. Reset (synchronous, active high) clears all gesture
// state and loads the register defaults.
module touch_gesture_recognizer #(
   parameter int COORD_WIDTH    = tgr_pkg::COORD_WIDTH_DEF,
   parameter int TIMER_WIDTH    = tgr_pkg::TIMER_WIDTH_DEF,
   parameter int DIST_FRAC_BITS = tgr_pkg::DIST_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // kind, first_state, first_x, first_y, first_last_x, first_last_y,
   // second_state, second_x, second_y (low to high, zero padded)
   input  logic [((6*COORD_WIDTH+6+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // event_res, pos_x, pos_y, delta_x, delta_y, pinch_delta (low to high)
   output logic [((3+4*COORD_WIDTH+2+COORD_WIDTH+3+DIST_FRAC_BITS+7)/8)*8-1:0]
                rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tgr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tgr_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1 + DIST_FRAC_BITS;
   localparam int PW  = DW + 2;
   localparam int SQW = 2 * DW;
   localparam int OUTW = EVENT_W + 4 * CW + 2 + PW;
   localparam int OPADW = ((OUTW + 7) / 8) * 8;
   localparam int MW = CW + 2;
   localparam int TCW = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_SQRT = 4'b0010, S_PINCH = 4'b0100, S_OUT = 4'b1000
   } state_type;

   typedef struct packed {
      logic [EVENT_W-1:0] ev;
      logic [CW-1:0]      px;
      logic [CW-1:0]      py;
      logic [CW:0]        dx;
      logic [CW:0]        dy;
      logic [PW-1:0]      pd;
   } result_type;

   state_type state_ff, state_in;

   logic [PAN_THR_W-1:0] pan_thr_ff;
   logic [PINCH_THR_W-1:0] pinch_thr_ff;
   logic [DTAP_W-1:0] dtap_dist_ff;
   logic [TICKS_W-1:0] hold_ticks_ff, dtap_ticks_ff;

   logic panning_ff, panning_in, pdet_ff, pdet_in, pinching_ff, pinching_in;
   logic [1:0] tap_cnt_ff, tap_cnt_in;
   logic signed [CW-1:0] tsx_ff, tsx_in, tsy_ff, tsy_in;
   logic hold_run_ff, hold_run_in, dbl_run_ff, dbl_run_in;
   logic [TIMER_WIDTH-1:0] hold_cnt_ff, hold_cnt_in, dbl_cnt_ff, dbl_cnt_in;
   logic [DW-1:0] base_ff, base_in;
   logic signed [PW-1:0] lastp_ff, lastp_in;

   result_type res_ff [2];
   result_type res_in [2];
   logic [1:0] nres_ff, nres_in, sel_ff, sel_in;

   logic [1:0] kind, st0, st1;
   logic signed [CW-1:0] x0, y0, lx, ly, x1, y1;
   logic signed [CW-1:0] hx0_ff, hy0_ff, hx1_ff, hy1_ff;
   logic signed [CW:0] dxs, dys;
   logic [CW:0] adx, ady;
   logic [2*CW+1:0] sqx, sqy, sq;
   logic [SQW-1:0] rad;
   logic sq_start, sq_done;
   logic [DW-1:0] sq_root;
   logic [DW-1:0] pdist;

   assign kind = req_tdata[1:0];
   assign st0  = req_tdata[3:2];
   assign x0   = req_tdata[4 +: CW];
   assign y0   = req_tdata[4+CW +: CW];
   assign lx   = req_tdata[4+2*CW +: CW];
   assign ly   = req_tdata[4+3*CW +: CW];
   assign st1  = req_tdata[4+4*CW +: 2];
   assign x1   = req_tdata[6+4*CW +: CW];
   assign y1   = req_tdata[6+5*CW +: CW];

   assign dxs = {x1[CW-1], x1} - {x0[CW-1], x0};
   assign dys = {y1[CW-1], y1} - {y0[CW-1], y0};
   assign adx = dxs[CW] ? (CW+1)'(0) - dxs : dxs;
   assign ady = dys[CW] ? (CW+1)'(0) - dys : dys;
   assign sqx = adx * adx;
   assign sqy = ady * ady;
   assign sq  = sqx + sqy;
   assign rad = SQW'(sq) << (2 * DIST_FRAC_BITS);

   tgr_isqrt #(.IN_W(SQW)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(rad),
      .done(sq_done), .root(sq_root)
   );
   assign pdist = sq_root;

   function automatic logic [MW-1:0] manh(input logic signed [CW-1:0] a,
      input logic signed [CW-1:0] b, input logic signed [CW-1:0] c,
      input logic signed [CW-1:0] d);
      logic signed [CW:0] e, f;
      logic [CW:0] ae, af;
      e = {a[CW-1], a} - {b[CW-1], b};
      f = {c[CW-1], c} - {d[CW-1], d};
      ae = e[CW] ? (CW+1)'(0) - e : e;
      af = f[CW] ? (CW+1)'(0) - f : f;
      return MW'(ae) + MW'(af);
   endfunction

   logic [MW-1:0] m_pan, m_dbl;
   assign m_pan = manh(x0, tsx_ff, y0, tsy_ff);
   assign m_dbl = manh(x0, tsx_ff, y0, tsy_ff);

   logic signed [DW+1:0] pd;
   logic [DW+1:0] apd;
   logic signed [PW:0] dl;
   logic signed [PW-1:0] dl_sat;
   logic signed [CW:0] sxm, sym;
   logic [TIMER_WIDTH-1:0] hc1, dc1;

   always_comb begin
      result_type r;
      logic [1:0] tc;
      logic pn, pg;
      state_in = state_ff;
      panning_in = panning_ff; pdet_in = pdet_ff; pinching_in = pinching_ff;
      tap_cnt_in = tap_cnt_ff; tsx_in = tsx_ff; tsy_in = tsy_ff;
      hold_run_in = hold_run_ff; hold_cnt_in = hold_cnt_ff;
      dbl_run_in = dbl_run_ff; dbl_cnt_in = dbl_cnt_ff;
      base_in = base_ff; lastp_in = lastp_ff;
      res_in[0] = res_ff[0]; res_in[1] = res_ff[1];
      nres_in = nres_ff; sel_in = sel_ff;
      sq_start = 1'b0;
      r = '0;
      pd = '0; apd = '0; dl = '0; dl_sat = '0;
      sxm = '0; sym = '0; hc1 = '0; dc1 = '0; tc = '0; pn = 1'b0; pg = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               nres_in = '0; sel_in = '0;
               state_in = S_OUT;
               case (kind)
                  KIND_TICK: begin
                     if (hold_run_ff) begin
                        hc1 = hold_cnt_ff + 1'b1;
                        if (TCW'(hc1) >= TCW'(hold_ticks_ff)) begin
                           hold_cnt_in = '0;
                           r.ev = EV_HOLD; r.px = tsx_ff; r.py = tsy_ff;
                           res_in[0] = r; nres_in = 2'd1;
                        end else hold_cnt_in = hc1;
                     end
                     if (dbl_run_ff) begin
                        dc1 = dbl_cnt_ff + 1'b1;
                        if (TCW'(dc1) >= TCW'(dtap_ticks_ff)) begin
                           dbl_cnt_in = '0; tap_cnt_in = '0;
                        end else dbl_cnt_in = dc1;
                     end
                  end
                  KIND_ONE: begin
                     if (st0 == ST_PRESSED) begin
                        tsx_in = x0; tsy_in = y0;
                        r.ev = EV_TAP_START; r.px = x0; r.py = y0;
                        res_in[0] = r; nres_in = 2'd1;
                        if (tap_cnt_ff == 2'd0) begin
                           dbl_run_in = 1'b1; dbl_cnt_in = '0;
                        end
                        tc = tap_cnt_ff + 1'b1;
                        tap_cnt_in = tc;
                        if (tc == 2'd2) begin
                           if (m_dbl < MW'(dtap_dist_ff)) begin
                              r.ev = EV_DOUBLE; res_in[1] = r; nres_in = 2'd2;
                           end
                           tap_cnt_in = '0;
                        end
                        hold_run_in = 1'b1; hold_cnt_in = '0;
                     end else if (st0 == ST_MOVED) begin
                        pn = panning_ff;
                        if (!panning_ff && m_pan > MW'(pan_thr_ff)) begin
                           pn = 1'b1; panning_in = 1'b1;
                           r = '0; r.ev = EV_PAN_START;
                           res_in[0] = r; nres_in = 2'd1;
                           hold_run_in = 1'b0; hold_cnt_in = '0;
                        end
                        if (pn) begin
                           r = '0; r.ev = EV_PAN; r.px = x0; r.py = y0;
                           r.dx = {x0[CW-1], x0} - {lx[CW-1], lx};
                           r.dy = {y0[CW-1], y0} - {ly[CW-1], ly};
                           if (panning_ff) begin
                              res_in[0] = r; nres_in = 2'd1;
                           end else begin
                              res_in[1] = r; nres_in = 2'd2;
                           end
                        end
                     end else if (st0 == ST_RELEASED) begin
                        if (!panning_ff) begin
                           r.ev = EV_TAP_END; r.px = x0; r.py = y0;
                        end else begin
                           panning_in = 1'b0; r.ev = EV_PAN_END;
                        end
                        res_in[0] = r; nres_in = 2'd1;
                        hold_run_in = 1'b0; hold_cnt_in = '0;
                     end
                  end
                  KIND_TWO: begin
                     if (st0 == ST_RELEASED || st1 == ST_RELEASED) begin
                        pdet_in = 1'b0; pinching_in = 1'b0;
                     end else begin
                        sq_start = 1'b1; state_in = S_SQRT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SQRT: begin
            if (sq_done) state_in = S_PINCH;
         end
         S_PINCH: begin
            state_in = S_OUT;
            pg = pinching_ff;
            base_in = pdet_ff ? base_ff : pdist;
            if (!pdet_ff) begin
               pdet_in = 1'b1;
               if (panning_ff) begin
                  panning_in = 1'b0; r = '0; r.ev = EV_PAN_END;
                  res_in[0] = r; nres_in = 2'd1;
               end
               hold_run_in = 1'b0; hold_cnt_in = '0;
               dbl_run_in = 1'b0; dbl_cnt_in = '0; tap_cnt_in = '0;
            end
            pd = (DW+2)'(pdist) - (DW+2)'(base_in);
            apd = pd[DW+1] ? (DW+2)'(0) - pd : pd;
            if (!pinching_ff && apd > (DW+2)'(pinch_thr_ff)) begin
               pg = 1'b1; pinching_in = 1'b1;
            end
            if (pg) begin
               dl = pinching_ff ? (PW+1)'(pd) - (PW+1)'(lastp_ff) : '0;
               if (dl > (PW+1)'((1 << (PW-1)) - 1)) dl_sat = {1'b0, {(PW-1){1'b1}}};
               else if (dl < -(PW+1)'(1 << (PW-1))) dl_sat = {1'b1, {(PW-1){1'b0}}};
               else dl_sat = dl[PW-1:0];
               lastp_in = PW'(pd);
               sxm = {hx0_ff[CW-1], hx0_ff} + {hx1_ff[CW-1], hx1_ff};
               sym = {hy0_ff[CW-1], hy0_ff} + {hy1_ff[CW-1], hy1_ff};
               r = '0; r.ev = EV_PINCH; r.px = sxm[CW:1]; r.py = sym[CW:1];
               r.pd = dl_sat;
               if (!pdet_ff && panning_ff) begin
                  res_in[1] = r; nres_in = 2'd2;
               end else begin
                  res_in[0] = r; nres_in = 2'd1;
               end
            end
         end
         S_OUT: begin
            if (nres_ff == sel_ff) state_in = S_IDLE;
            else if (rsp_tready) begin
               sel_in = sel_ff + 1'b1;
               if (sel_ff + 1'b1 == nres_ff) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pan_thr_ff <= PAN_THR_RST; pinch_thr_ff <= PINCH_THR_RST;
         dtap_dist_ff <= DTAP_DIST_RST; hold_ticks_ff <= HOLD_RST;
         dtap_ticks_ff <= DTAP_TICKS_RST;
         panning_ff <= 1'b0; pdet_ff <= 1'b0; pinching_ff <= 1'b0;
         tap_cnt_ff <= '0; tsx_ff <= '0; tsy_ff <= '0;
         hold_run_ff <= 1'b0; hold_cnt_ff <= '0;
         dbl_run_ff <= 1'b0; dbl_cnt_ff <= '0;
         base_ff <= '0; lastp_ff <= '0;
         nres_ff <= '0; sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PAN_THR:    pan_thr_ff <= csr_wdata[PAN_THR_W-1:0];
               CSR_PINCH_THR:  pinch_thr_ff <= csr_wdata[PINCH_THR_W-1:0];
               CSR_DTAP_DIST:  dtap_dist_ff <= csr_wdata[DTAP_W-1:0];
               CSR_HOLD_TICKS: hold_ticks_ff <= csr_wdata[TICKS_W-1:0];
               CSR_DTAP_TICKS: dtap_ticks_ff <= csr_wdata[TICKS_W-1:0];
               default: ;
            endcase
         end
         panning_ff <= panning_in; pdet_ff <= pdet_in; pinching_ff <= pinching_in;
         tap_cnt_ff <= tap_cnt_in; tsx_ff <= tsx_in; tsy_ff <= tsy_in;
         hold_run_ff <= hold_run_in; hold_cnt_ff <= hold_cnt_in;
         dbl_run_ff <= dbl_run_in; dbl_cnt_ff <= dbl_cnt_in;
         base_ff <= base_in; lastp_ff <= lastp_in;
         nres_ff <= nres_in; sel_ff <= sel_in;
      end
      res_ff[0] <= res_in[0]; res_ff[1] <= res_in[1];
      if (state_ff == S_IDLE) begin
         hx0_ff <= x0; hy0_ff <= y0; hx1_ff <= x1; hy1_ff <= y1;
      end
   end

   result_type cur;
   assign cur = res_ff[sel_ff[0]];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT) && (sel_ff != nres_ff);
   assign rsp_tlast  = (sel_ff + 1'b1 == nres_ff);
   assign rsp_tdata  = OPADW'({cur.pd, cur.dy, cur.dx, cur.py, cur.px, cur.ev});
endmodule

@@ sv/tgr_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// No dependencies.
module tgr_isqrt #(
   parameter int IN_W = 42
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IN_W-1:0]   radicand,
   output logic              done,
   output logic [IN_W/2-1:0] root
);
   localparam int RW = IN_W / 2;
   localparam int CW = $clog2(RW + 1);
   logic [IN_W-1:0] rem_ff, rem_in, val_ff, val_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [IN_W+1:0] trial, shifted;

   always_comb begin
      rem_in = rem_ff; val_in = val_ff; root_in = root_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff, val_ff[IN_W-1 -: 2]};
      trial = shifted - {root_ff, 2'b01};
      if (start) begin
         rem_in = '0; val_in = radicand; root_in = '0;
         cnt_in = CW'(RW); busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[IN_W-3:0], 2'b00};
         if (!trial[IN_W+1]) begin
            rem_in = trial[IN_W-1:0];
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = shifted[IN_W-1:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; val_ff <= val_in; root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

@@ sv/tgr_checker.sv @@
// Port-level checker for the touch gesture recognizer, bound to the top.
// Depends on tgr_pkg.
module tgr_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);
   import tgr_pkg::*;
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while results pending");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after last");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast)
);
